### hdl/afth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afth_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS = 24;

  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [31:0] PI_Q24 = 32'sd52707179;
  localparam logic signed [33:0] K_Q30 = 34'sd652032875;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [15:0] GAIN_RESET = 16'd328;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
  } car_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
  } side_t;

  function automatic logic signed [31:0] atan_q24(input int i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd13176795;
      1: v = 32'sd7778716;
      2: v = 32'sd4110059;
      3: v = 32'sd2086331;
      4: v = 32'sd1047214;
      5: v = 32'sd524118;
      6: v = 32'sd262123;
      7: v = 32'sd131069;
      default: v = 32'sd65536 >>> (i - 8);
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd16384) begin
      r = ONE_Q14;
    end else if (v < -34'sd16384) begin
      r = -ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/attitude_fusion_tilt_heading_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  gyro and accel angles, body-frame magnetometer
// out_      output     out_valid/out_stall fused angles, heading, gravity, world magnetometer
// cfg_      input      cfg_we             blend_gain
//
// One item enters per cycle while the output is not stalled; the path runs through the
// rotation CORDIC for sine and cosine followed by the vectoring CORDIC for heading.
// Reset clears all valid bits and loads blend_gain with its default.
// A stall on the output freezes the whole pipeline in place while out_valid is high.

module attitude_fusion_tilt_heading_top #(
  parameter int CORDIC_STEPS = afth_pkg::CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_gyro_roll,
  input  wire logic signed [15:0] in_gyro_pitch,
  input  wire logic signed [15:0] in_gyro_yaw,
  input  wire logic signed [15:0] in_accel_roll,
  input  wire logic signed [15:0] in_accel_pitch,
  input  wire logic signed [15:0] in_mag_body_x,
  input  wire logic signed [15:0] in_mag_body_y,
  input  wire logic signed [15:0] in_mag_body_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_fused_roll,
  output logic signed [15:0]      out_fused_pitch,
  output logic signed [15:0]      out_heading,
  output logic signed [15:0]      out_grav_x,
  output logic signed [15:0]      out_grav_y,
  output logic signed [15:0]      out_grav_z,
  output logic signed [15:0]      out_mag_world_x,
  output logic signed [15:0]      out_mag_world_y,
  output logic signed [15:0]      out_mag_world_z,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int N = CORDIC_STEPS;
  localparam int S3 = 2;
  localparam int ST = S3 + N + 2;
  localparam int P3 = ST + 3;
  localparam int SH = P3 + N + 2;
  localparam int OUT = SH + 1;

  logic adv;
  logic [OUT:0] vld_r;
  logic [15:0] gain_r;

  logic signed [15:0] s1_gr_r, s1_gp_r, s1_ar_r, s1_ap_r, s1_yaw_r;
  logic signed [15:0] s1_mx_r, s1_my_r, s1_mz_r;
  logic signed [16:0] d_roll, d_pitch;
  logic signed [33:0] s2_pr_r, s2_pp_r;
  logic signed [15:0] s2_gr_r, s2_gp_r, s2_yaw_r;
  logic signed [15:0] s2_mx_r, s2_my_r, s2_mz_r;
  logic signed [17:0] t_roll, t_pitch;
  logic signed [17:0] f_roll, f_pitch;
  logic signed [15:0] s3_yaw_r;
  afth_pkg::car_t s3_car_r;
  afth_pkg::car_t car_r [0:N+1];

  logic signed [15:0] sr, cr, sp, cp, sy, cy;

  afth_pkg::car_t p1_car_r;
  logic signed [31:0] p1_spsr_r, p1_spcr_r, p1_cpsr_r, p1_cpcr_r;
  logic signed [31:0] p1_cycp_r, p1_sycp_r, p1_crmy_r, p1_srmz_r, p1_cpmx_r;
  logic signed [15:0] p1_sr_r, p1_cr_r, p1_sp_r, p1_sy_r, p1_cy_r;

  logic signed [31:0] spsr_w, spcr_w;
  logic signed [15:0] spsr, spcr;
  afth_pkg::car_t p2_car_r;
  logic signed [15:0] p2_gy_r, p2_gz_r, p2_sp_r;
  logic signed [31:0] p2_spsrmy_r, p2_spcrmz_r;
  logic signed [31:0] p2_cyspsr_r, p2_sycr_r, p2_cyspcr_r, p2_sysr_r;
  logic signed [31:0] p2_syspsr_r, p2_cycr_r, p2_syspcr_r, p2_cysr_r;
  logic signed [31:0] p2_cpmx_r, p2_crmy_r, p2_srmz_r, p2_cycp_r, p2_sycp_r;
  logic signed [31:0] p2_cpsr_r, p2_cpcr_r;

  afth_pkg::car_t p3_car_r;
  logic signed [15:0] p3_gx_r, p3_gy_r, p3_gz_r;
  logic signed [33:0] p3_lx_r, p3_ly_r;
  logic signed [31:0] p3_r_r [0:8];

  afth_pkg::car_t p4_car_r;
  logic signed [15:0] p4_gx_r, p4_gy_r, p4_gz_r;
  logic signed [47:0] p4_m_r [0:8];

  logic signed [49:0] wsum [0:2];
  logic signed [21:0] wrnd [0:2];
  logic signed [15:0] wsat [0:2];
  afth_pkg::side_t p5_side;
  afth_pkg::side_t side_r [0:N];

  logic signed [15:0] head;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      gain_r <= afth_pkg::GAIN_RESET;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (adv) begin
        vld_r <= {vld_r[OUT-1:0], in_valid};
      end
    end
  end

  assign d_roll = {s1_ar_r[15], s1_ar_r} - {s1_gr_r[15], s1_gr_r};
  assign d_pitch = {s1_ap_r[15], s1_ap_r} - {s1_gp_r[15], s1_gp_r};
  assign t_roll = 18'((s2_pr_r + 34'sd32768) >>> 16);
  assign t_pitch = 18'((s2_pp_r + 34'sd32768) >>> 16);
  assign f_roll = {{2{s2_gr_r[15]}}, s2_gr_r} + t_roll;
  assign f_pitch = {{2{s2_gp_r[15]}}, s2_gp_r} + t_pitch;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gr_r <= in_gyro_roll;
      s1_gp_r <= in_gyro_pitch;
      s1_ar_r <= in_accel_roll;
      s1_ap_r <= in_accel_pitch;
      s1_yaw_r <= in_gyro_yaw;
      s1_mx_r <= in_mag_body_x;
      s1_my_r <= in_mag_body_y;
      s1_mz_r <= in_mag_body_z;

      s2_pr_r <= d_roll * $signed({1'b0, gain_r});
      s2_pp_r <= d_pitch * $signed({1'b0, gain_r});
      s2_gr_r <= s1_gr_r;
      s2_gp_r <= s1_gp_r;
      s2_yaw_r <= s1_yaw_r;
      s2_mx_r <= s1_mx_r;
      s2_my_r <= s1_my_r;
      s2_mz_r <= s1_mz_r;

      s3_yaw_r <= s2_yaw_r;
      s3_car_r.roll <= f_roll[15:0];
      s3_car_r.pitch <= f_pitch[15:0];
      s3_car_r.mx <= s2_mx_r;
      s3_car_r.my <= s2_my_r;
      s3_car_r.mz <= s2_mz_r;

      car_r[0] <= s3_car_r;
      for (int k = 1; k < N + 2; k++) begin
        car_r[k] <= car_r[k-1];
      end
    end
  end

  afth_sincos #(.STEPS(N)) u_sc_roll (
    .clk(clk), .en(adv), .ang(s3_car_r.roll), .sin_q(sr), .cos_q(cr)
  );
  afth_sincos #(.STEPS(N)) u_sc_pitch (
    .clk(clk), .en(adv), .ang(s3_car_r.pitch), .sin_q(sp), .cos_q(cp)
  );
  afth_sincos #(.STEPS(N)) u_sc_yaw (
    .clk(clk), .en(adv), .ang(s3_yaw_r), .sin_q(sy), .cos_q(cy)
  );

  assign spsr_w = (p1_spsr_r + 32'sd8192) >>> 14;
  assign spcr_w = (p1_spcr_r + 32'sd8192) >>> 14;
  assign spsr = spsr_w[15:0];
  assign spcr = spcr_w[15:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_car_r <= car_r[N+1];
      p1_spsr_r <= sp * sr;
      p1_spcr_r <= sp * cr;
      p1_cpsr_r <= cp * sr;
      p1_cpcr_r <= cp * cr;
      p1_cycp_r <= cy * cp;
      p1_sycp_r <= sy * cp;
      p1_crmy_r <= cr * car_r[N+1].my;
      p1_srmz_r <= sr * car_r[N+1].mz;
      p1_cpmx_r <= cp * car_r[N+1].mx;
      p1_sr_r <= sr;
      p1_cr_r <= cr;
      p1_sp_r <= sp;
      p1_sy_r <= sy;
      p1_cy_r <= cy;

      p2_car_r <= p1_car_r;
      p2_gy_r <= afth_pkg::clamp_q14(34'((p1_cpsr_r + 32'sd8192) >>> 14));
      p2_gz_r <= afth_pkg::clamp_q14(34'((p1_cpcr_r + 32'sd8192) >>> 14));
      p2_sp_r <= p1_sp_r;
      p2_spsrmy_r <= spsr * p1_car_r.my;
      p2_spcrmz_r <= spcr * p1_car_r.mz;
      p2_cyspsr_r <= p1_cy_r * spsr;
      p2_sycr_r <= p1_sy_r * p1_cr_r;
      p2_cyspcr_r <= p1_cy_r * spcr;
      p2_sysr_r <= p1_sy_r * p1_sr_r;
      p2_syspsr_r <= p1_sy_r * spsr;
      p2_cycr_r <= p1_cy_r * p1_cr_r;
      p2_syspcr_r <= p1_sy_r * spcr;
      p2_cysr_r <= p1_cy_r * p1_sr_r;
      p2_cpmx_r <= p1_cpmx_r;
      p2_crmy_r <= p1_crmy_r;
      p2_srmz_r <= p1_srmz_r;
      p2_cycp_r <= p1_cycp_r;
      p2_sycp_r <= p1_sycp_r;
      p2_cpsr_r <= p1_cpsr_r;
      p2_cpcr_r <= p1_cpcr_r;

      p3_car_r <= p2_car_r;
      p3_gx_r <= -p2_sp_r;
      p3_gy_r <= p2_gy_r;
      p3_gz_r <= p2_gz_r;
      p3_lx_r <= 34'(p2_cpmx_r) + 34'(p2_spsrmy_r) + 34'(p2_spcrmz_r);
      p3_ly_r <= 34'(p2_crmy_r) - 34'(p2_srmz_r);
      p3_r_r[0] <= p2_cycp_r;
      p3_r_r[1] <= p2_cyspsr_r - p2_sycr_r;
      p3_r_r[2] <= p2_cyspcr_r + p2_sysr_r;
      p3_r_r[3] <= p2_sycp_r;
      p3_r_r[4] <= p2_syspsr_r + p2_cycr_r;
      p3_r_r[5] <= p2_syspcr_r - p2_cysr_r;
      p3_r_r[6] <= -(32'(p2_sp_r) <<< 14);
      p3_r_r[7] <= p2_cpsr_r;
      p3_r_r[8] <= p2_cpcr_r;

      p4_car_r <= p3_car_r;
      p4_gx_r <= p3_gx_r;
      p4_gy_r <= p3_gy_r;
      p4_gz_r <= p3_gz_r;
      for (int k = 0; k < 3; k++) begin
        p4_m_r[3*k] <= p3_r_r[3*k] * p3_car_r.mx;
        p4_m_r[3*k+1] <= p3_r_r[3*k+1] * p3_car_r.my;
        p4_m_r[3*k+2] <= p3_r_r[3*k+2] * p3_car_r.mz;
      end

      side_r[0] <= p5_side;
      for (int k = 1; k < N + 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wsum[k] = 50'(p4_m_r[3*k]) + 50'(p4_m_r[3*k+1]) + 50'(p4_m_r[3*k+2]);
      wrnd[k] = 22'((wsum[k] + 50'sd134217728) >>> 28);
      if (wrnd[k] > 22'sd32767) begin
        wsat[k] = 16'sd32767;
      end else if (wrnd[k] < -22'sd32768) begin
        wsat[k] = -16'sd32768;
      end else begin
        wsat[k] = wrnd[k][15:0];
      end
    end
    p5_side.roll = p4_car_r.roll;
    p5_side.pitch = p4_car_r.pitch;
    p5_side.gx = p4_gx_r;
    p5_side.gy = p4_gy_r;
    p5_side.gz = p4_gz_r;
    p5_side.wx = wsat[0];
    p5_side.wy = wsat[1];
    p5_side.wz = wsat[2];
  end

  afth_atan2 #(.STEPS(N)) u_heading (
    .clk(clk),
    .en(adv),
    .y_in({{2{p3_ly_r[33]}}, p3_ly_r, 16'd0}),
    .x_in({{2{p3_lx_r[33]}}, p3_lx_r, 16'd0}),
    .ang(head)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fused_roll <= side_r[N].roll;
      out_fused_pitch <= side_r[N].pitch;
      out_heading <= head;
      out_grav_x <= side_r[N].gx;
      out_grav_y <= side_r[N].gy;
      out_grav_z <= side_r[N].gz;
      out_mag_world_x <= side_r[N].wx;
      out_mag_world_y <= side_r[N].wy;
      out_mag_world_z <= side_r[N].wz;
    end
  end

endmodule

`default_nettype wire

### hdl/afth_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module afth_sincos #(
  parameter int STEPS = afth_pkg::CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] ang,
  output logic signed [15:0]      sin_q,
  output logic signed [15:0]      cos_q
);

  logic signed [16:0] red;
  logic               neg;
  logic signed [33:0] x_r [0:STEPS];
  logic signed [33:0] y_r [0:STEPS];
  logic signed [31:0] z_r [0:STEPS];
  logic               neg_r [0:STEPS];
  logic signed [33:0] cr;
  logic signed [33:0] sr;
  logic signed [15:0] cc;
  logic signed [15:0] sc;

  always_comb begin
    red = {ang[15], ang};
    neg = 1'b0;
    if (red > afth_pkg::HALF_PI_Q13) begin
      red = red - afth_pkg::PI_Q13;
      neg = 1'b1;
    end else if (red < -afth_pkg::HALF_PI_Q13) begin
      red = red + afth_pkg::PI_Q13;
      neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= afth_pkg::K_Q30;
      y_r[0] <= '0;
      z_r[0] <= {{15{red[16]}}, red} <<< 11;
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][31]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - afth_pkg::atan_q24(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + afth_pkg::atan_q24(i);
        end
      end
    end
  end

  always_comb begin
    cr = (x_r[STEPS] + 34'sd32768) >>> 16;
    sr = (y_r[STEPS] + 34'sd32768) >>> 16;
    cc = afth_pkg::clamp_q14(cr);
    sc = afth_pkg::clamp_q14(sr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= neg_r[STEPS] ? -cc : cc;
      sin_q <= neg_r[STEPS] ? -sc : sc;
    end
  end

endmodule

`default_nettype wire

### hdl/afth_atan2.sv
`timescale 1ns / 1ps
`default_nettype none

module afth_atan2 #(
  parameter int STEPS = afth_pkg::CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [51:0] y_in,
  input  wire logic signed [51:0] x_in,
  output logic signed [15:0]      ang
);

  logic signed [51:0] x_r [0:STEPS];
  logic signed [51:0] y_r [0:STEPS];
  logic signed [31:0] z_r [0:STEPS];
  logic               zero_r [0:STEPS];
  logic signed [31:0] zr;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[51]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= y_in[51] ? -afth_pkg::PI_Q24 : afth_pkg::PI_Q24;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][51]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + afth_pkg::atan_q24(i);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - afth_pkg::atan_q24(i);
        end
      end
    end
  end

  assign zr = (z_r[STEPS] + 32'sd1024) >>> 11;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[STEPS]) begin
        ang <= '0;
      end else if (zr > 32'sd25736) begin
        ang <= 16'sd25736;
      end else if (zr < -32'sd25736) begin
        ang <= -16'sd25736;
      end else begin
        ang <= zr[15:0];
      end
    end
  end

endmodule

`default_nettype wire
